// ----- design/pwes_pkg.sv -----
// Shared types, constants and codes of the packed width element store.
package pwes_pkg;

	localparam int STORE_BYTES_DEF = 4096;
	localparam int MAX_WIDTH_DEF = 32;

	localparam int CFG_W = 6;
	localparam int VALUE_W = 32;
	localparam int INDEX_W = 15;
	localparam int COUNT_W = 16;
	localparam int STATUS_W = 2;

	localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd8;
	localparam logic [COUNT_W-1:0] MAX_COUNT = 16'd32768;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [VALUE_W-1:0]  read_value;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  element_count;
	} res_t;

endpackage

// ----- design/pwes_byte_ram.sv -----
// Byte-wide synchronous memory with one write port and one registered read port.
module pwes_byte_ram #(
	parameter int DEPTH = pwes_pkg::STORE_BYTES_DEF,
	parameter int AW = $clog2(pwes_pkg::STORE_BYTES_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/pwes_ctrl.sv -----
// Sequencer that clears the store and walks the bytes of one element per item.
module pwes_ctrl #(
	parameter int STORE_BYTES = pwes_pkg::STORE_BYTES_DEF,
	parameter int MAX_WIDTH = pwes_pkg::MAX_WIDTH_DEF,
	parameter int AW = $clog2(STORE_BYTES),
	parameter int WW = $clog2(MAX_WIDTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [WW-1:0]                 ew,
	input  logic                          start,
	input  logic                          operation,
	input  logic [pwes_pkg::VALUE_W-1:0]  value,
	input  logic [pwes_pkg::INDEX_W-1:0]  index,
	output logic                          idle,
	output logic                          res_valid,
	input  logic                          res_take,
	output pwes_pkg::res_t                res,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic [7:0]                    ram_wdata,
	output logic                          ram_re,
	output logic [AW-1:0]                 ram_raddr,
	input  logic [7:0]                    ram_rdata
);

	localparam int NB = (MAX_WIDTH + 14) / 8;
	localparam int NBW = $clog2(NB + 1);
	localparam int DW = NB * 8;
	localparam int PA = pwes_pkg::COUNT_W + WW + 1;
	localparam int PB = AW + 4;
	localparam int PW = (PA > PB) ? PA : PB;
	localparam int BW = PW - 3;
	localparam logic [PW-1:0] STORE_BITS = PW'(STORE_BYTES) << 3;
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MUL = 3'd2;
	localparam logic [2:0] S_CHK = 3'd3;
	localparam logic [2:0] S_BYTES = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [AW-1:0] clr_q;
	logic op_q;
	logic [pwes_pkg::VALUE_W-1:0] value_q;
	logic [pwes_pkg::INDEX_W-1:0] index_q;
	logic [PW-1:0] pos_q;
	logic [pwes_pkg::COUNT_W-1:0] count_q;
	logic [pwes_pkg::STATUS_W-1:0] status_q;
	logic [BW-1:0] base_q;
	logic [2:0] off_q;
	logic [NBW-1:0] nbytes_q;
	logic [NBW-1:0] rd_k_q;
	logic [DW-1:0] data_q;
	logic [DW-1:0] mask_q;
	logic [DW-1:0] acc_q;

	logic rd_valid_s1;
	logic [NBW-1:0] rd_k_s1;
	logic [AW-1:0] rd_addr_s1;
	logic rd_inr_s1;

	logic [BW-1:0] byte_addr;
	logic addr_inr;
	logic [DW-1:0] mask_full;
	logic [WW:0] span;
	logic full;
	logic out_of_range;
	logic [7:0] mask_byte;
	logic [7:0] data_byte;
	logic [DW-1:0] rd_field;

	assign byte_addr = base_q + BW'(rd_k_q);
	assign addr_inr = byte_addr < BW'(STORE_BYTES);
	assign mask_full = (DW'(1) << ew) - DW'(1);
	assign span = (WW + 1)'(pos_q[2:0]) + (WW + 1)'(ew) + (WW + 1)'(7);
	assign full = (count_q >= pwes_pkg::MAX_COUNT) || ((pos_q + PW'(ew)) > STORE_BITS);
	assign out_of_range = {1'b0, index_q} >= count_q;
	assign mask_byte = mask_q[{rd_k_s1, 3'b000} +: 8];
	assign data_byte = data_q[{rd_k_s1, 3'b000} +: 8];
	assign rd_field = (acc_q & mask_q) >> off_q;

	assign idle = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE) && !rd_valid_s1;
	assign res.read_value = (op_q == pwes_pkg::OP_READ && status_q == pwes_pkg::ST_OK) ?
		pwes_pkg::VALUE_W'(rd_field) : '0;
	assign res.status = status_q;
	assign res.element_count = count_q;

	assign ram_re = (state_q == S_BYTES || state_q == S_FIN) && addr_inr;
	assign ram_raddr = byte_addr[AW-1:0];

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = (ram_rdata & ~mask_byte) | (data_byte & mask_byte);
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 8'h00;
		end else if (rd_valid_s1 && rd_inr_s1 && op_q == pwes_pkg::OP_APPEND) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == S_BYTES || state_q == S_FIN);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if ((op_q == pwes_pkg::OP_APPEND && full) ||
						(op_q == pwes_pkg::OP_READ && out_of_range)) begin
						state_q <= S_DONE;
					end else if (NBW'(span[WW:3]) == NBW'(1)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_BYTES;
					end
				end
				S_BYTES: begin
					if (rd_k_q + NBW'(2) == nbytes_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_DONE;
					if (op_q == pwes_pkg::OP_APPEND) begin
						count_q <= count_q + pwes_pkg::COUNT_W'(1);
					end
				end
				S_DONE: begin
					if (res_valid && res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_k_s1 <= rd_k_q;
		rd_addr_s1 <= byte_addr[AW-1:0];
		rd_inr_s1 <= addr_inr;
		if (rd_valid_s1) begin
			acc_q[{rd_k_s1, 3'b000} +: 8] <= rd_inr_s1 ? ram_rdata : 8'h00;
		end
		case (state_q)
			S_IDLE: begin
				op_q <= operation;
				value_q <= value;
				index_q <= index;
			end
			S_MUL: begin
				pos_q <= PW'(((op_q == pwes_pkg::OP_READ) ? {1'b0, index_q} : count_q) * ew);
			end
			S_CHK: begin
				status_q <= pwes_pkg::ST_OK;
				if (op_q == pwes_pkg::OP_APPEND && full) begin
					status_q <= pwes_pkg::ST_FULL;
				end else if (op_q == pwes_pkg::OP_READ && out_of_range) begin
					status_q <= pwes_pkg::ST_RANGE;
				end
				base_q <= pos_q[PW-1:3];
				off_q <= pos_q[2:0];
				nbytes_q <= NBW'(span[WW:3]);
				data_q <= (DW'(value_q) & mask_full) << pos_q[2:0];
				mask_q <= mask_full << pos_q[2:0];
				acc_q <= '0;
				rd_k_q <= '0;
			end
			S_BYTES: begin
				rd_k_q <= rd_k_q + NBW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/packed_width_element_store_unit.sv -----
// Top level of the packed width element store: configuration, sequencer, memory and output.
//
// Elements of element_width bits (0 acts as 1, values above MAX_WIDTH act as MAX_WIDTH)
// are packed least significant bit first into a byte store of STORE_BYTES bytes.
// The input channel (in_valid/in_ready) carries operation, value and index; the output
// channel (out_valid/out_ready) returns read_value, status and element_count, one
// transfer out for every transfer in, in order.
// An item touches B = ceil((bit offset + width) / 8) bytes, at most 5 for 32-bit
// elements. The sequencer reads one byte per cycle from the store and writes the
// merged byte back in the following cycle. A full append or an out-of-range read
// skips the byte walk. The next input is taken only after the previous result has
// moved into the output register.
// After reset the store is cleared one byte per cycle, all STORE_BYTES bytes (4096 by
// default), with in_ready low; cfg_write_en writes element_width at any time.
// A finished result waits in the output register while the receiver stalls, and the
// next item can already be accepted and processed; it then holds until the register frees.
module packed_width_element_store_unit #(
	parameter int STORE_BYTES = pwes_pkg::STORE_BYTES_DEF,
	parameter int MAX_WIDTH = pwes_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [pwes_pkg::CFG_W-1:0]     cfg_write_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [pwes_pkg::VALUE_W-1:0]   value,
	input  logic [pwes_pkg::INDEX_W-1:0]   index,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [pwes_pkg::VALUE_W-1:0]   read_value,
	output logic [pwes_pkg::STATUS_W-1:0]  status,
	output logic [pwes_pkg::COUNT_W-1:0]   element_count
);

	localparam int AW = $clog2(STORE_BYTES);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	logic [pwes_pkg::CFG_W-1:0] width_q;
	logic [WW-1:0] ew;
	logic ctrl_idle;
	logic res_valid;
	logic res_take;
	pwes_pkg::res_t res;
	pwes_pkg::res_t res_q;
	logic out_valid_q;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0] ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= pwes_pkg::WIDTH_RESET;
		end else if (cfg_write_en) begin
			width_q <= cfg_write_data;
		end
	end

	always_comb begin
		if (width_q == '0) begin
			ew = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			ew = WW'(MAX_WIDTH);
		end else begin
			ew = WW'(width_q);
		end
	end

	assign in_ready = ctrl_idle;
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign read_value = res_q.read_value;
	assign status = res_q.status;
	assign element_count = res_q.element_count;

	pwes_ctrl #(
		.STORE_BYTES(STORE_BYTES),
		.MAX_WIDTH(MAX_WIDTH),
		.AW(AW),
		.WW(WW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.ew(ew),
		.start(in_valid && in_ready),
		.operation(operation),
		.value(value),
		.index(index),
		.idle(ctrl_idle),
		.res_valid(res_valid),
		.res_take(res_take),
		.res(res),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re(ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	pwes_byte_ram #(
		.DEPTH(STORE_BYTES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// ----- tb/sv/tb_packed_width_element_store_unit.sv -----
// Self-checking testbench for the packed width element store, with a bit-level store predictor.
module tb_packed_width_element_store_unit;

	localparam int CFG_W = pwes_pkg::CFG_W;
	localparam int VALUE_W = pwes_pkg::VALUE_W;
	localparam int INDEX_W = pwes_pkg::INDEX_W;
	localparam int STATUS_W = pwes_pkg::STATUS_W;
	localparam int COUNT_W = pwes_pkg::COUNT_W;
	localparam int STORE_BITS = pwes_pkg::STORE_BYTES_DEF * 8;
	localparam int QUIET_LIMIT = 20000;

	typedef struct {
		logic               op;
		logic [VALUE_W-1:0] val;
		logic [INDEX_W-1:0] idx;
	} store_req_t;

	typedef enum logic [1:0] {GAPS_RX_HEAVY, GAPS_TX_HEAVY, GAPS_NONE} gap_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write_en = 1'b0;
	logic [CFG_W-1:0]    cfg_write_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                operation = pwes_pkg::OP_APPEND;
	logic [VALUE_W-1:0]  value = '0;
	logic [INDEX_W-1:0]  index = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [VALUE_W-1:0]  read_value;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  element_count;

	packed_width_element_store_unit uut (.*);

	logic [7:0]       shadow_bytes [0:pwes_pkg::STORE_BYTES_DEF-1];
	int               stored_elems = 0;
	logic [CFG_W-1:0] shadow_width = pwes_pkg::WIDTH_RESET;

	store_req_t      pending_reqs[$];
	pwes_pkg::res_t  expected_results[$];

	gap_mode_t gap_mode = GAPS_RX_HEAVY;
	int        tx_gap_pct;
	int        rx_gap_pct;
	logic      in_taken = 1'b0;
	int        rx_hold_left = 0;
	logic      long_hold_done = 1'b0;

	int items_queued = 0;
	int results_seen = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	int appends_stored = 0;
	int full_drops = 0;
	int reads_hit = 0;
	int range_reads = 0;
	int width_writes = 0;

	always #6 clk = ~clk;

	always_comb begin
		tx_gap_pct = (gap_mode == GAPS_RX_HEAVY) ? 28 : (gap_mode == GAPS_TX_HEAVY) ? 84 : 0;
		rx_gap_pct = (gap_mode == GAPS_RX_HEAVY) ? 84 : (gap_mode == GAPS_TX_HEAVY) ? 28 : 0;
	end

	function automatic pwes_pkg::res_t store_apply(input logic op,
			input logic [VALUE_W-1:0] val, input logic [INDEX_W-1:0] idx);
		pwes_pkg::res_t r;
		int w;
		int base;
		int pos;
		r = '0;
		w = (shadow_width == 0) ? 1 :
			(int'(shadow_width) > pwes_pkg::MAX_WIDTH_DEF) ? pwes_pkg::MAX_WIDTH_DEF :
			int'(shadow_width);
		if (op == pwes_pkg::OP_APPEND) begin
			base = stored_elems * w;
			if (stored_elems >= int'(pwes_pkg::MAX_COUNT) || base + w > STORE_BITS) begin
				r.status = pwes_pkg::ST_FULL;
			end else begin
				for (int k = 0; k < w; k++) begin
					pos = base + k;
					shadow_bytes[pos / 8][pos % 8] = val[k];
				end
				stored_elems++;
			end
		end else begin
			if (int'(idx) >= stored_elems) begin
				r.status = pwes_pkg::ST_RANGE;
			end else begin
				base = int'(idx) * w;
				for (int k = 0; k < w; k++) begin
					pos = base + k;
					if (pos < STORE_BITS)
						r.read_value[k] = shadow_bytes[pos / 8][pos % 8];
				end
			end
		end
		r.element_count = COUNT_W'(stored_elems);
		return r;
	endfunction

	always @(negedge clk) begin
		store_req_t req;
		if (!in_valid || in_taken) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
				req = pending_reqs.pop_front();
				operation <= req.op;
				value <= req.val;
				index <= req.idx;
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_ready <= 1'b0;
		end else if (gap_mode == GAPS_NONE && !long_hold_done) begin
			long_hold_done <= 1'b1;
			rx_hold_left <= 150;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= rx_gap_pct);
	end

	always @(posedge clk) begin
		pwes_pkg::res_t want;
		pwes_pkg::res_t got;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			want = store_apply(operation, value, index);
			expected_results = {expected_results, want};
			case (want.status)
				pwes_pkg::ST_FULL: full_drops++;
				pwes_pkg::ST_RANGE: range_reads++;
				default: if (operation == pwes_pkg::OP_APPEND) appends_stored++;
					else reads_hit++;
			endcase
		end
		if (out_valid && out_ready) begin
			results_seen++;
			got.read_value = read_value;
			got.status = status;
			got.element_count = element_count;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: read_value %h status %0d count %0d",
					$time, got.read_value, got.status, got.element_count);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.read_value !== want.read_value) begin
					$display("%0t: read_value expected %h got %h", $time,
						want.read_value, got.read_value);
					error_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
					error_count++;
				end
				if (got.element_count !== want.element_count) begin
					$display("%0t: element_count expected %0d got %0d", $time,
						want.element_count, got.element_count);
					error_count++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("tb_packed_width_element_store_unit: errors");
			$finish;
		end
	end

	task automatic queue_item(input logic op, input logic [VALUE_W-1:0] val,
			input logic [INDEX_W-1:0] idx);
		store_req_t req;
		while (pending_reqs.size() > 3)
			@(posedge clk);
		req.op = op;
		req.val = val;
		req.idx = idx;
		pending_reqs = {pending_reqs, req};
		items_queued++;
	endtask

	task automatic drain_results();
		wait (results_seen == items_queued);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_element_width(input logic [CFG_W-1:0] w);
		drain_results();
		cfg_write_en <= 1'b1;
		cfg_write_data <= w;
		shadow_width = w;
		width_writes++;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic random_chunk(input logic [CFG_W-1:0] w, input int n, input int append_pct);
		logic [VALUE_W-1:0] val;
		logic [INDEX_W-1:0] idx;
		int pick;
		set_element_width(w);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: val = '0;
				1: val = '1;
				2: val = $urandom() >> $urandom_range(31);
				default: val = $urandom();
			endcase
			pick = $urandom_range(99);
			if (pick < 70)
				idx = (stored_elems > 0) ? INDEX_W'($urandom_range(stored_elems - 1)) : '0;
			else if (pick < 80)
				idx = INDEX_W'(stored_elems);
			else
				idx = INDEX_W'($urandom());
			queue_item(($urandom_range(99) < append_pct) ? pwes_pkg::OP_APPEND :
				pwes_pkg::OP_READ, val, idx);
		end
	endtask

	initial begin
		for (int i = 0; i < pwes_pkg::STORE_BYTES_DEF; i++)
			shadow_bytes[i] = 8'h00;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		queue_item(pwes_pkg::OP_READ, '0, 15'd0);
		queue_item(pwes_pkg::OP_READ, '0, 15'd32767);
		queue_item(pwes_pkg::OP_APPEND, 32'hFFFF_FFFF, '0);
		queue_item(pwes_pkg::OP_APPEND, 32'h0000_0000, '0);
		queue_item(pwes_pkg::OP_APPEND, 32'h1234_5678, '0);
		queue_item(pwes_pkg::OP_READ, '0, 15'd0);
		queue_item(pwes_pkg::OP_READ, '0, 15'd1);
		queue_item(pwes_pkg::OP_READ, '0, 15'd2);
		queue_item(pwes_pkg::OP_READ, '0, 15'd3);
		set_element_width(6'd0);
		queue_item(pwes_pkg::OP_APPEND, 32'h0000_0001, '0);
		queue_item(pwes_pkg::OP_APPEND, 32'hFFFF_FFFE, '0);
		queue_item(pwes_pkg::OP_APPEND, 32'h0000_0003, '0);
		queue_item(pwes_pkg::OP_READ, '0, 15'd4);
		queue_item(pwes_pkg::OP_READ, '0, 15'd0);
		queue_item(pwes_pkg::OP_READ, '0, 15'd5);
		set_element_width(6'd63);
		queue_item(pwes_pkg::OP_APPEND, 32'hFFFF_FFFF, '0);
		queue_item(pwes_pkg::OP_APPEND, 32'h8000_0001, '0);
		queue_item(pwes_pkg::OP_READ, '0, 15'd6);
		queue_item(pwes_pkg::OP_READ, '0, 15'd7);
		queue_item(pwes_pkg::OP_READ, '0, 15'd2);
		set_element_width(6'd32);
		queue_item(pwes_pkg::OP_READ, '0, 15'd7);
		queue_item(pwes_pkg::OP_APPEND, 32'hDEAD_BEEF, '0);
		queue_item(pwes_pkg::OP_READ, '0, 15'd8);

		random_chunk(6'd1, 100, 75);
		random_chunk(CFG_W'($urandom_range(0, 63)), 100, 75);
		random_chunk(CFG_W'($urandom_range(0, 63)), 100, 75);
		drain_results();
		gap_mode = GAPS_TX_HEAVY;
		random_chunk(6'd13, 100, 75);
		random_chunk(CFG_W'($urandom_range(0, 63)), 100, 75);
		random_chunk(6'd8, 100, 75);
		drain_results();
		gap_mode = GAPS_NONE;
		repeat (3)
			random_chunk(CFG_W'($urandom_range(0, 63)), 100, 90);
		drain_results();

		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			error_count++;
		end
		$display("Covered %0d transfers in: %0d appends stored, %0d dropped as full,",
			items_queued, appends_stored, full_drops);
		$display("%0d reads in range, %0d out of range, %0d width writes, %0d mismatches.",
			reads_hit, range_reads, width_writes, error_count);
		if (error_count == 0)
			$display("tb_packed_width_element_store_unit: clean");
		else
			$display("tb_packed_width_element_store_unit: errors");
		$finish;
	end

endmodule

// ----- packed_width_element_store_unit.f -----
design/pwes_pkg.sv
design/pwes_byte_ram.sv
design/pwes_ctrl.sv
design/packed_width_element_store_unit.sv
tb/sv/tb_packed_width_element_store_unit.sv
